// ===== rtl/dpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distortion pedal chain package
// Shared formats, constants, register indexes and the controller/datapath
// command interface.
// ----------------------------------------------------------------------------
package dpc_pkg;

  // Defaults for the top-level parameters.
  localparam int DefNumChannels = 2;
  localparam int DefSampleWidth = 24;

  // Internal Q16.24 values are held in 40 bits.
  localparam int IW = 40;
  typedef logic signed [IW-1:0] q40_t;

  // Configuration port.
  localparam int NumRegs  = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HP1_ALPHA  = 3'd0,
    REG_HP2_ALPHA  = 3'd1,
    REG_HP3_ALPHA  = 3'd2,
    REG_HP4_ALPHA  = 3'd3,
    REG_LP_CLEAN   = 3'd4,
    REG_TONE_ALPHA = 3'd5,
    REG_DRIVE_GAIN = 3'd6,
    REG_VOLUME     = 3'd7
  } reg_idx_e;

  localparam logic [CfgDataW-1:0] RegReset [NumRegs] = '{
    24'd16769972, 24'd16705057, 24'd16726851, 24'd16618403,
    24'd8140133,  24'd1941913,  24'd762733,   24'd65536
  };

  // Fixed 35 dB boost as a Q8.16 gain, and the clip threshold in Q16.24.
  localparam logic [CfgDataW-1:0] BoostQ16 = 24'd3685360;
  localparam q40_t ClipPos = 40'sd11744051;
  localparam q40_t ClipNeg = -40'sd11744051;

  localparam logic signed [IW+1:0] SatHi = 42'sd549755813887;
  localparam logic signed [IW+1:0] SatLo = -42'sd549755813888;

  // Filter state words kept per channel.
  localparam int NumWords = 10;
  typedef enum logic [3:0] {
    W_HPY0 = 4'd0,
    W_HPY1 = 4'd1,
    W_HPY2 = 4'd2,
    W_HPY3 = 4'd3,
    W_HPX0 = 4'd4,
    W_HPX1 = 4'd5,
    W_HPX2 = 4'd6,
    W_HPX3 = 4'd7,
    W_LPC  = 4'd8,
    W_LPT  = 4'd9
  } word_e;

  // Processing steps of the chain, in order.
  typedef enum logic [3:0] {
    OP_HP1,
    OP_HP2,
    OP_BOOST,
    OP_HP3,
    OP_DRIVE,
    OP_HP4,
    OP_LPC,
    OP_LPT,
    OP_VOL
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_DIFF,
    ST_MUL_LD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_RND,
    ST_FIN,
    ST_NARROW,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    YS_HOLD,
    YS_MUL,
    YS_LP,
    YS_LPC,
    YS_CLIP
  } ysel_e;

  typedef enum logic [1:0] {
    WS_Y,
    WS_MUL,
    WS_LP
  } wsel_e;

  typedef struct packed {
    logic     take;
    logic     rd_en;
    word_e    rd_word;
    logic     wr_en;
    word_e    wr_word;
    wsel_e    wr_sel;
    logic     t_load;
    logic     t_sub;
    logic     s_load;
    logic     s_hp;
    logic     mul_load;
    logic     mul_src_y;
    logic     use_boost;
    reg_idx_e coef_sel;
    logic     sh16;
    logic     mul_lo;
    logic     mul_hi;
    logic     mul_rnd;
    ysel_e    y_sel;
    logic     n_load;
    logic     out_load;
  } dpc_cmd_t;

  typedef struct packed {
    logic out_full;
  } dpc_status_t;

  function automatic logic signed [IW+1:0] ext42(input q40_t v);
    return {{2{v[IW-1]}}, v};
  endfunction

  function automatic q40_t sat40(input logic signed [IW+1:0] v);
    logic signed [IW+1:0] r;
    r = v;
    if (v > SatHi) begin
      r = SatHi;
    end else if (v < SatLo) begin
      r = SatLo;
    end
    return r[IW-1:0];
  endfunction

endpackage

// ===== rtl/dpc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaling multiplier
// Signed 40-bit value times unsigned 24-bit coefficient, built from two
// 20x24 partial products, then rounded (ties away from zero) and saturated.
// ----------------------------------------------------------------------------
module dpc_mul (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  dpc_pkg::q40_t               v_i,
  input  logic [dpc_pkg::CfgDataW-1:0] m_i,
  input  logic                        sh16_i,
  input  logic                        lo_i,
  input  logic                        hi_i,
  input  logic                        rnd_i,
  output dpc_pkg::q40_t               res_o
);
  import dpc_pkg::*;

  localparam int HW = IW / 2;
  localparam int PW = HW + CfgDataW;
  localparam logic [48:0] Lim = 49'd1 << (IW - 1);

  logic                neg_q;
  logic [IW-1:0]       mag_q;
  logic [CfgDataW-1:0] m_q;
  logic                sh16_q;
  logic [63:0]         p_q;
  q40_t                res_q;
  q40_t                res_d;

  logic [IW-1:0] v_u;
  logic [HW-1:0] op_half;
  logic [PW-1:0] half_prod;
  logic [48:0]   pr;

  assign v_u       = unsigned'(v_i);
  assign op_half   = hi_i ? mag_q[IW-1:HW] : mag_q[HW-1:0];
  assign half_prod = PW'(op_half) * PW'(m_q);

  // The magnitude is rounded at the cut, the sign is put back afterwards.
  always_comb begin
    if (sh16_q) begin
      pr = 49'(p_q[63:16]) + 49'(p_q[15]);
    end else begin
      pr = 49'(p_q[63:24]) + 49'(p_q[23]);
    end
    if (neg_q) begin
      res_d = (pr >= Lim) ? q40_t'(SatLo[IW-1:0]) : -signed'(pr[IW-1:0]);
    end else begin
      res_d = (pr > (Lim - 49'd1)) ? q40_t'(SatHi[IW-1:0]) : signed'(pr[IW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      neg_q  <= v_i[IW-1];
      mag_q  <= v_i[IW-1] ? (~v_u + 40'd1) : v_u;
      m_q    <= m_i;
      sh16_q <= sh16_i;
    end
    if (lo_i) begin
      p_q <= 64'(half_prod);
    end else if (hi_i) begin
      p_q <= p_q + (64'(half_prod) << HW);
    end
    if (rnd_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/dpc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distortion pedal chain datapath
// Configuration registers, per-channel filter state memory, working
// registers, the scaling multiplier and the output register.
// ----------------------------------------------------------------------------
module dpc_datapath #(
  parameter int NUM_CHANNELS = dpc_pkg::DefNumChannels,
  parameter int SAMPLE_WIDTH = dpc_pkg::DefSampleWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dpc_pkg::dpc_cmd_t                   cmd_i,
  output dpc_pkg::dpc_status_t                status_o,
  input  logic                                chan_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  input  logic                                cfg_we_i,
  input  logic [dpc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [dpc_pkg::CfgDataW-1:0]        cfg_wdata_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out_o,
  output logic                                clip_hit_o
);
  import dpc_pkg::*;

  localparam int Depth = NUM_CHANNELS * NumWords;
  localparam int AW    = $clog2(Depth);
  localparam logic signed [47:0] OutMax = (48'sd1 <<< (SAMPLE_WIDTH - 1)) - 48'sd1;
  localparam logic signed [47:0] OutMin = -(48'sd1 <<< (SAMPLE_WIDTH - 1));

  logic [CfgDataW-1:0] cfg_q [NumRegs];

  logic [IW-1:0] state_mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [IW-1:0] rd_mem_q;
  logic          rd_vld_q;

  logic                          chan_q;
  q40_t                          y_q, y_d;
  logic                          clipped_q, clipped_d;
  logic signed [IW+1:0]          t_q;
  q40_t                          s_q;
  logic signed [SAMPLE_WIDTH-1:0] n_q, n_d;
  logic                          out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
  logic                          clip_out_q;

  logic [AW-1:0]       base, rd_addr, wr_addr;
  q40_t                rd_val, mul_res, lp_new, wr_data, widened;
  logic [CfgDataW-1:0] mul_m;
  logic signed [47:0]  nv;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        cfg_q[i] <= RegReset[i];
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------- state memory
  assign base    = chan_q ? AW'(NumWords) : '0;
  assign rd_addr = base + AW'(cmd_i.rd_word);
  assign wr_addr = base + AW'(cmd_i.wr_word);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      state_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_mem_q <= state_mem[rd_addr];
    end
  end

  // An entry that has never been written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  assign rd_val = rd_vld_q ? signed'(rd_mem_q) : '0;

  // -------------------------------------------------------- input widening
  if (SAMPLE_WIDTH <= 25) begin : g_wid_shl
    localparam int WSH = 25 - SAMPLE_WIDTH;
    assign widened = signed'({{(IW - SAMPLE_WIDTH){sample_in_i[SAMPLE_WIDTH-1]}},
                              sample_in_i} << WSH);
  end else begin : g_wid_rnd
    localparam int WSH = SAMPLE_WIDTH - 25;
    logic [SAMPLE_WIDTH-1:0] xmag, xr;
    logic [IW-1:0]           xr40;
    assign xmag = sample_in_i[SAMPLE_WIDTH-1] ?
                  (~unsigned'(sample_in_i) + SAMPLE_WIDTH'(1)) : unsigned'(sample_in_i);
    assign xr   = (xmag >> WSH) + SAMPLE_WIDTH'(xmag[WSH-1]);
    assign xr40 = IW'(xr);
    assign widened = sample_in_i[SAMPLE_WIDTH-1] ? -signed'(xr40) : signed'(xr40);
  end

  // ------------------------------------------------------------ multiplier
  assign mul_m = cmd_i.use_boost ? BoostQ16 : cfg_q[cmd_i.coef_sel];

  dpc_mul u_mul (
    .clk_i  (clk_i),
    .load_i (cmd_i.mul_load),
    .v_i    (cmd_i.mul_src_y ? y_q : s_q),
    .m_i    (mul_m),
    .sh16_i (cmd_i.sh16),
    .lo_i   (cmd_i.mul_lo),
    .hi_i   (cmd_i.mul_hi),
    .rnd_i  (cmd_i.mul_rnd),
    .res_o  (mul_res)
  );

  // --------------------------------------------------------- working regs
  assign lp_new = sat40(ext42(rd_val) + ext42(mul_res));

  always_comb begin
    unique case (cmd_i.wr_sel)
      WS_Y:    wr_data = y_q;
      WS_MUL:  wr_data = mul_res;
      WS_LP:   wr_data = lp_new;
      default: wr_data = y_q;
    endcase
  end

  always_comb begin
    y_d       = y_q;
    clipped_d = clipped_q;
    if (cmd_i.take) begin
      y_d       = widened;
      clipped_d = 1'b0;
    end else begin
      unique case (cmd_i.y_sel)
        YS_HOLD: y_d = y_q;
        YS_MUL:  y_d = mul_res;
        YS_LP:   y_d = lp_new;
        YS_LPC:  y_d = clipped_q ? y_q : lp_new;
        YS_CLIP: begin
          if (mul_res > ClipPos) begin
            y_d       = ClipPos;
            clipped_d = 1'b1;
          end else if (mul_res < ClipNeg) begin
            y_d       = ClipNeg;
            clipped_d = 1'b1;
          end else begin
            y_d = mul_res;
          end
        end
        default: y_d = y_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q    <= 1'b0;
      clipped_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        chan_q <= (NUM_CHANNELS > 1) ? chan_i : 1'b0;
      end
      clipped_q <= clipped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
    if (cmd_i.t_load) begin
      t_q <= cmd_i.t_sub ? (ext42(y_q) - ext42(rd_val)) : (ext42(y_q) + ext42(rd_val));
    end
    if (cmd_i.s_load) begin
      s_q <= cmd_i.s_hp ? sat40(t_q - ext42(rd_val)) : sat40(t_q);
    end
    if (cmd_i.n_load) begin
      n_q <= n_d;
    end
  end

  // ------------------------------------------------------- output narrowing
  if (SAMPLE_WIDTH >= 25) begin : g_nar_shl
    localparam int NSH = SAMPLE_WIDTH - 25;
    assign nv = signed'({{8{y_q[IW-1]}}, y_q} << NSH);
  end else begin : g_nar_rnd
    localparam int NSH = 25 - SAMPLE_WIDTH;
    logic [IW-1:0] nmag, nrnd;
    assign nmag = y_q[IW-1] ? (~unsigned'(y_q) + 40'd1) : unsigned'(y_q);
    assign nrnd = (nmag >> NSH) + IW'(nmag[NSH-1]);
    assign nv   = y_q[IW-1] ? -signed'({8'b0, nrnd}) : signed'({8'b0, nrnd});
  end

  always_comb begin
    if (nv > OutMax) begin
      n_d = OutMax[SAMPLE_WIDTH-1:0];
    end else if (nv < OutMin) begin
      n_d = OutMin[SAMPLE_WIDTH-1:0];
    end else begin
      n_d = nv[SAMPLE_WIDTH-1:0];
    end
  end

  // --------------------------------------------------------- output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sample_out_q <= n_q;
      clip_out_q   <= clipped_q;
    end
  end

  assign status_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clip_hit_o   = clip_out_q;

endmodule

// ===== rtl/dpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distortion pedal chain controller
// Steps one sample through the chain of filters and gains, issuing memory,
// multiplier and register commands to the datapath.
// ----------------------------------------------------------------------------
module dpc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dpc_pkg::dpc_status_t status_i,
  output dpc_pkg::dpc_cmd_t    cmd_o
);
  import dpc_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic     is_hp, is_lp, is_gain;
  word_e    w_hpy, w_hpx, w_lp;
  reg_idx_e coef;

  function automatic op_e next_op(input op_e op);
    op_e n;
    n = OP_VOL;
    unique case (op)
      OP_HP1:   n = OP_HP2;
      OP_HP2:   n = OP_BOOST;
      OP_BOOST: n = OP_HP3;
      OP_HP3:   n = OP_DRIVE;
      OP_DRIVE: n = OP_HP4;
      OP_HP4:   n = OP_LPC;
      OP_LPC:   n = OP_LPT;
      OP_LPT:   n = OP_VOL;
      OP_VOL:   n = OP_VOL;
      default:  n = OP_VOL;
    endcase
    return n;
  endfunction

  function automatic logic op_is_gain(input op_e op);
    return (op == OP_BOOST) || (op == OP_DRIVE) || (op == OP_VOL);
  endfunction

  // Per-step decode: which state words and which coefficient belong to it.
  always_comb begin
    is_hp = 1'b0;
    is_lp = 1'b0;
    w_hpy = W_HPY0;
    w_hpx = W_HPX0;
    w_lp  = W_LPC;
    coef  = REG_HP1_ALPHA;
    unique case (op_q)
      OP_HP1: begin
        is_hp = 1'b1;
      end
      OP_HP2: begin
        is_hp = 1'b1;
        w_hpy = W_HPY1;
        w_hpx = W_HPX1;
        coef  = REG_HP2_ALPHA;
      end
      OP_HP3: begin
        is_hp = 1'b1;
        w_hpy = W_HPY2;
        w_hpx = W_HPX2;
        coef  = REG_HP3_ALPHA;
      end
      OP_HP4: begin
        is_hp = 1'b1;
        w_hpy = W_HPY3;
        w_hpx = W_HPX3;
        coef  = REG_HP4_ALPHA;
      end
      OP_LPC: begin
        is_lp = 1'b1;
        coef  = REG_LP_CLEAN;
      end
      OP_LPT: begin
        is_lp = 1'b1;
        w_lp  = W_LPT;
        coef  = REG_TONE_ALPHA;
      end
      OP_DRIVE: coef = REG_DRIVE_GAIN;
      OP_VOL:   coef = REG_VOLUME;
      OP_BOOST: coef = REG_HP1_ALPHA;
      default:  coef = REG_HP1_ALPHA;
    endcase
    is_gain = op_is_gain(op_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RD_A;
          op_d    = OP_HP1;
        end
      end
      ST_RD_A:    state_d = ST_RD_B;
      ST_RD_B:    state_d = ST_DIFF;
      ST_DIFF:    state_d = ST_MUL_LD;
      ST_MUL_LD:  state_d = ST_MUL_LO;
      ST_MUL_LO:  state_d = ST_MUL_HI;
      ST_MUL_HI:  state_d = ST_MUL_RND;
      ST_MUL_RND: state_d = ST_FIN;
      ST_FIN: begin
        if (op_q == OP_VOL) begin
          state_d = ST_NARROW;
        end else begin
          op_d    = next_op(op_q);
          state_d = op_is_gain(next_op(op_q)) ? ST_MUL_LD : ST_RD_A;
        end
      end
      ST_NARROW:  state_d = ST_OUT;
      ST_OUT: begin
        if (!status_i.out_full) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o           = '0;
    cmd_o.rd_word   = W_HPY0;
    cmd_o.wr_word   = W_HPY0;
    cmd_o.wr_sel    = WS_Y;
    cmd_o.coef_sel  = coef;
    cmd_o.y_sel     = YS_HOLD;
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_RD_A: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_word = is_hp ? w_hpy : w_lp;
      end
      ST_RD_B: begin
        // Previous output is on the read data; fetch the previous HP input.
        cmd_o.t_load  = 1'b1;
        cmd_o.t_sub   = is_lp;
        cmd_o.rd_en   = is_hp;
        cmd_o.rd_word = w_hpx;
      end
      ST_DIFF: begin
        cmd_o.s_load  = 1'b1;
        cmd_o.s_hp    = is_hp;
        cmd_o.wr_en   = is_hp;
        cmd_o.wr_word = w_hpx;
        cmd_o.wr_sel  = WS_Y;
      end
      ST_MUL_LD: begin
        cmd_o.mul_load  = 1'b1;
        cmd_o.mul_src_y = is_gain;
        cmd_o.use_boost = (op_q == OP_BOOST);
        cmd_o.sh16      = is_gain;
      end
      ST_MUL_LO:  cmd_o.mul_lo  = 1'b1;
      ST_MUL_HI:  cmd_o.mul_hi  = 1'b1;
      ST_MUL_RND: cmd_o.mul_rnd = 1'b1;
      ST_FIN: begin
        if (is_hp) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_word = w_hpy;
          cmd_o.wr_sel  = WS_MUL;
          cmd_o.y_sel   = YS_MUL;
        end else if (is_lp) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_word = w_lp;
          cmd_o.wr_sel  = WS_LP;
          cmd_o.y_sel   = (op_q == OP_LPC) ? YS_LPC : YS_LP;
        end else begin
          cmd_o.y_sel = (op_q == OP_DRIVE) ? YS_CLIP : YS_MUL;
        end
      end
      ST_NARROW: cmd_o.n_load   = 1'b1;
      ST_OUT:    cmd_o.out_load = !status_i.out_full;
      default:   cmd_o.take     = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_HP1;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ===== rtl/distortion_pedal_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distortion pedal chain
// Per-channel one-pole filter chain with boost, drive, hard clip, tone and
// volume, in fixed point with saturation.
// ----------------------------------------------------------------------------
//   Channel   Handshake                 Payload
//   input     in_valid_i / in_ready_o   chan_i, sample_in_i
//   output    out_valid_o / out_ready_i sample_out_o, clip_hit_o
//   config    cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// A request is taken, then stepped through each of the six filters and the
// three gains in turn, all sharing the one 20x24 multiplier (two partial
// products per scaling) and the state memory; the result is then narrowed
// and handed over to the output register.
// After reset the registers hold their defaults and all filter state reads
// as zero. A finished result waits in the output register; the next request
// is taken meanwhile, and its own result waits if that register is still full.
// ----------------------------------------------------------------------------
module distortion_pedal_chain #(
  parameter int NUM_CHANNELS = dpc_pkg::DefNumChannels,
  parameter int SAMPLE_WIDTH = dpc_pkg::DefSampleWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           chan_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           clip_hit_o,
  input  logic                           cfg_we_i,
  input  logic [dpc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dpc_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import dpc_pkg::*;

  dpc_cmd_t    cmd;
  dpc_status_t status;

  dpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dpc_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .chan_i       (chan_i),
    .sample_in_i  (sample_in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .clip_hit_o   (clip_hit_o)
  );

endmodule
